// ===== design/ctcgd_pkg.sv =====
// shared types and constants of the ctc greedy decoder
`timescale 1ns / 1ps
package ctcgd_pkg;

  localparam int MaxClasses = 256;
  localparam int MaxSteps   = 64;

  localparam int ScoreW     = 32;
  localparam int SymW       = 8;
  localparam int ClassCntW  = 9;
  localparam int StepCntW   = 7;
  localparam int ClassPosW  = 8;
  localparam int StepPosW   = 6;
  localparam int ZpW        = 8;
  localparam int ScaleW     = 32;
  localparam int DiffW      = ZpW + 1;
  localparam int ValW       = DiffW + ScaleW;

  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 32;

  localparam logic [CfgIdxW-1:0] REG_CLASS_COUNT    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_STEP_COUNT     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_QUANTIZED_MODE = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ZERO_POINT     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DEQUANT_SCALE  = 3'd4;

  localparam logic [ClassCntW-1:0] CLASS_COUNT_RST = 9'd78;
  localparam logic [StepCntW-1:0]  STEP_COUNT_RST  = 7'd20;
  localparam logic [ScaleW-1:0]    SCALE_RST       = 32'h0001_0000;

  localparam logic [SymW-1:0] BLANK = '0;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic signed [ValW-1:0] value;
    logic [SymW-1:0]        cls;
    logic                   first;
    logic                   last_class;
    logic                   last_step;
  } q_entry_t;

endpackage

// ===== design/ctcgd_if.sv =====
// stream and configuration channel interfaces
`timescale 1ns / 1ps

interface ctcgd_score_if;
  import ctcgd_pkg::*;
  logic              valid;
  logic              ready;
  logic [ScoreW-1:0] score;
  modport source (output valid, output score, input ready);
  modport sink (input valid, input score, output ready);
endinterface

interface ctcgd_result_if;
  import ctcgd_pkg::*;
  logic            valid;
  logic            ready;
  logic [SymW-1:0] symbol;
  logic            has_symbol;
  logic            sequence_end;
  modport source (output valid, output symbol, output has_symbol, output sequence_end,
                  input ready);
  modport sink (input valid, input symbol, input has_symbol, input sequence_end,
                output ready);
endinterface

interface ctcgd_cfg_if;
  import ctcgd_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/ctcgd_front.sv =====
// front end: config registers, score dequantization and position tracking
`timescale 1ns / 1ps
module ctcgd_front import ctcgd_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  ctcgd_cfg_if.sink      cfg_i,
  ctcgd_score_if.sink    in_i,
  input  logic           q_full_i,
  output logic           push_o,
  output q_entry_t       entry_o
);

  logic [ClassCntW-1:0]    class_count_q;
  logic [StepCntW-1:0]     step_count_q;
  logic                    quant_q;
  logic signed [ZpW-1:0]   zp_q;
  logic signed [ScaleW-1:0] scale_q;

  logic [ClassPosW-1:0] class_pos_q, class_pos_d;
  logic [StepPosW-1:0]  step_pos_q, step_pos_d;

  logic [ClassCntW-1:0]   classes;
  logic [StepCntW-1:0]    steps;
  logic                   last_class;
  logic                   last_step;
  logic signed [DiffW-1:0] diff;
  logic signed [ValW-1:0]  value;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_count_q <= CLASS_COUNT_RST;
      step_count_q  <= STEP_COUNT_RST;
      quant_q       <= 1'b1;
      zp_q          <= '0;
      scale_q       <= SCALE_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_CLASS_COUNT:    class_count_q <= cfg_i.data[ClassCntW-1:0];
        REG_STEP_COUNT:     step_count_q  <= cfg_i.data[StepCntW-1:0];
        REG_QUANTIZED_MODE: quant_q       <= cfg_i.data[0];
        REG_ZERO_POINT:     zp_q          <= cfg_i.data[ZpW-1:0];
        REG_DEQUANT_SCALE:  scale_q       <= cfg_i.data[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  // saturate counts into their legal ranges
  always_comb begin
    if (class_count_q == '0) begin
      classes = ClassCntW'(1);
    end else if (class_count_q > ClassCntW'(MaxClasses)) begin
      classes = ClassCntW'(MaxClasses);
    end else begin
      classes = class_count_q;
    end
    if (step_count_q == '0) begin
      steps = StepCntW'(1);
    end else if (step_count_q > StepCntW'(MaxSteps)) begin
      steps = StepCntW'(MaxSteps);
    end else begin
      steps = step_count_q;
    end
  end

  assign last_class = ({1'b0, class_pos_q} + ClassCntW'(1)) >= classes;
  assign last_step  = ({1'b0, step_pos_q} + StepCntW'(1)) >= steps;

  assign diff  = DiffW'(signed'(in_i.score[ZpW-1:0])) - DiffW'(zp_q);
  assign value = quant_q ? ValW'(diff) * ValW'(scale_q)
                         : ValW'(signed'(in_i.score));

  assign in_i.ready = !q_full_i;
  assign push_o     = in_i.valid && !q_full_i;

  assign entry_o.value      = value;
  assign entry_o.cls        = class_pos_q;
  assign entry_o.first      = (class_pos_q == '0);
  assign entry_o.last_class = last_class;
  assign entry_o.last_step  = last_step;

  always_comb begin
    class_pos_d = class_pos_q;
    step_pos_d  = step_pos_q;
    if (push_o) begin
      if (last_class) begin
        class_pos_d = '0;
        step_pos_d  = last_step ? '0 : step_pos_q + StepPosW'(1);
      end else begin
        class_pos_d = class_pos_q + ClassPosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_pos_q <= '0;
      step_pos_q  <= '0;
    end else begin
      class_pos_q <= class_pos_d;
      step_pos_q  <= step_pos_d;
    end
  end

endmodule

// ===== design/ctcgd_queue.sv =====
// short fifo between front and back
`timescale 1ns / 1ps
module ctcgd_queue import ctcgd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t wdata_i,
  input  logic     pop_i,
  output logic     full_o,
  output logic     valid_o,
  output q_entry_t rdata_o
);

  q_entry_t         mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q, count_d;

  assign full_o  = (count_q == QCntW'(QDepth));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_comb begin
    count_d = count_q;
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + QCntW'(1);
      2'b01:   count_d = count_q - QCntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      count_q <= count_d;
    end
  end

endmodule

// ===== design/ctcgd_back.sv =====
// back end: running maximum, collapse of repeats and blanks, result register
`timescale 1ns / 1ps
module ctcgd_back import ctcgd_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  q_entry_t       q_data_i,
  output logic           pop_o,
  ctcgd_result_if.source out_o
);

  logic signed [ValW-1:0] best_q, best_d;
  logic [SymW-1:0]        best_cls_q, best_cls_d;
  logic [SymW-1:0]        prev_q, prev_d;

  logic            out_valid_q, out_valid_d;
  logic [SymW-1:0] out_sym_q;
  logic            out_has_q, out_end_q;

  logic            take;
  logic [SymW-1:0] winner;
  logic            emit;
  logic            has_result;
  logic            slot_free;

  assign take   = q_data_i.first || (q_data_i.value > best_q);
  assign winner = take ? q_data_i.cls : best_cls_q;
  assign emit   = (winner != BLANK) && (winner != prev_q);

  assign has_result = q_data_i.last_class && (emit || q_data_i.last_step);
  assign slot_free  = !out_valid_q || out_o.ready;
  assign pop_o      = q_valid_i && (!has_result || slot_free);

  always_comb begin
    best_d     = best_q;
    best_cls_d = best_cls_q;
    prev_d     = prev_q;
    if (pop_o) begin
      if (take) begin
        best_d     = q_data_i.value;
        best_cls_d = q_data_i.cls;
      end
      if (q_data_i.last_class) begin
        prev_d = q_data_i.last_step ? BLANK : winner;
      end
    end
  end

  assign out_valid_d = (pop_o && has_result) || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q      <= '0;
      best_cls_q  <= '0;
      prev_q      <= BLANK;
      out_valid_q <= 1'b0;
    end else begin
      best_q      <= best_d;
      best_cls_q  <= best_cls_d;
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && has_result) begin
      out_sym_q <= emit ? winner : BLANK;
      out_has_q <= emit;
      out_end_q <= q_data_i.last_step;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.symbol       = out_sym_q;
  assign out_o.has_symbol   = out_has_q;
  assign out_o.sequence_end = out_end_q;

endmodule

// ===== design/ctc_greedy_decoder.sv =====
// top level of the ctc greedy (best-path) decoder
`timescale 1ns / 1ps
// Greedy CTC decoder. Class scores arrive one per request, timestep-major:
// class_count scores form a timestep and step_count timesteps a sequence.
// Each score is dequantized in the front end (int8 minus zero point, times
// a signed Q16.16 scale, exact 41-bit product; or the raw Q16.16 value in
// direct mode), tagged with its class index and its end-of-timestep and
// end-of-sequence flags, and written into a four-entry queue. The back end
// drains the queue, keeps the running maximum per timestep (ties keep the
// earliest class, class zero always loads) and at the end of a timestep
// emits the winning class unless it is blank or repeats the previous winner.
// The last timestep of a sequence always produces a result, with
// sequence_end set, and clears the previous winner. A timestep without an
// emitted symbol that is not the last one produces no result at all.
// Throughput is one score per clock cycle while the queue has room, set by
// the single 9x32 multiplier in the front end and the single compare in the
// back end; a closing score passes through the queue, and the back end
// loads its result into the output register when it pops that score.
// The queue and the output register let a stall on the result side hold the
// back end while the front end keeps taking scores until the queue fills.
// Configuration writes are accepted every cycle and must only be issued
// while no score is in flight.
module ctc_greedy_decoder import ctcgd_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  ctcgd_cfg_if.sink      cfg_i,
  ctcgd_score_if.sink    in_i,
  ctcgd_result_if.source out_o
);

  // front to queue
  logic     push;
  q_entry_t push_entry;
  logic     q_full;

  // queue to back
  logic     q_valid;
  q_entry_t q_head;
  logic     pop;

  ctcgd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_i),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  ctcgd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .rdata_o (q_head)
  );

  ctcgd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_head),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule

// ===== sim/tb_top.sv =====
// testbench of the ctc greedy decoder: random score streams checked against a best-path model
`timescale 1ns / 1ps

module tb_top;
  import ctcgd_pkg::*;

  // stop point of the random part and the bounds of the run
  localparam int RandomItems   = 1300;
  // cycles a score may still sit in the queue after the last result
  localparam int DrainCycles   = 16;
  // cycles with no request moving on any channel before giving up
  localparam int WatchdogLimit = 3000;

  // indexes past the last register, which the block must ignore
  localparam logic [CfgIdxW-1:0] REG_FIRST_UNUSED = REG_DEQUANT_SCALE + 3'd1;

  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            has_symbol;
    logic            sequence_end;
  } decoded_t;

  // receiver behavior, switched to a random mode after a random stretch
  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_CHOKED, RX_PULSED} rx_mode_e;

  // best-path scoreboard: keeps its own copy of the settings and the decoder
  // state, and queues the decoded symbols that the block must produce
  class best_path_board;
    logic [ClassCntW-1:0]     class_count;
    logic [StepCntW-1:0]      step_count;
    logic                     quant;
    logic signed [ZpW-1:0]    zp_val;
    logic signed [ScaleW-1:0] scale;

    longint          best_score;
    logic [SymW-1:0] best_class;
    int unsigned     class_pos;
    int unsigned     step_pos;
    logic [SymW-1:0] prev_sym;

    decoded_t symbols_due[$];
    int       errors;
    int       results_seen;

    function new();
      class_count  = CLASS_COUNT_RST;
      step_count   = STEP_COUNT_RST;
      quant        = 1'b1;
      zp_val       = '0;
      scale        = SCALE_RST;
      best_score   = 0;
      best_class   = BLANK;
      class_pos    = 0;
      step_pos     = 0;
      prev_sym     = BLANK;
      errors       = 0;
      results_seen = 0;
    endfunction

    // counts outside the legal range saturate when used
    function int unsigned class_limit();
      if (class_count == 0) return 1;
      return (class_count > MaxClasses) ? MaxClasses : class_count;
    endfunction

    function int unsigned step_limit();
      if (step_count == 0) return 1;
      return (step_count > MaxSteps) ? MaxSteps : step_count;
    endfunction

    function int pending();
      return symbols_due.size();
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_CLASS_COUNT:    class_count = data[ClassCntW-1:0];
        REG_STEP_COUNT:     step_count  = data[StepCntW-1:0];
        REG_QUANTIZED_MODE: quant       = data[0];
        REG_ZERO_POINT:     zp_val      = data[ZpW-1:0];
        REG_DEQUANT_SCALE:  scale       = data[ScaleW-1:0];
        default: ;
      endcase
    endfunction

    function void note_score(logic [ScoreW-1:0] score);
      longint          value;
      logic [SymW-1:0] winner;
      bit              emit;
      bit              last;
      decoded_t        due;
      if (quant)
        value = (longint'($signed(score[7:0])) - longint'(zp_val)) * longint'(scale);
      else
        value = longint'($signed(score));

      // first class always loads, later ones only when strictly greater
      if (class_pos == 0 || value > best_score) begin
        best_score = value;
        best_class = class_pos[SymW-1:0];
      end

      // a position at or past the count ends the timestep at once
      if (class_pos + 1 < class_limit()) begin
        class_pos = (class_pos + 1) % MaxClasses;
        return;
      end

      class_pos = 0;
      winner    = best_class;
      emit      = (winner != BLANK) && (winner != prev_sym);
      last      = (step_pos + 1 >= step_limit());
      if (last) begin
        step_pos = 0;
        prev_sym = BLANK;
      end else begin
        step_pos = (step_pos + 1) % MaxSteps;
        prev_sym = winner;
      end

      if (emit || last) begin
        due.symbol       = emit ? winner : BLANK;
        due.has_symbol   = emit;
        due.sequence_end = last;
        symbols_due.insert(symbols_due.size(), due);
      end
    endfunction

    function void check_result(decoded_t got);
      decoded_t want;
      results_seen++;
      if (symbols_due.size() == 0) begin
        $error("result with none expected: symbol %0d has_symbol %0b sequence_end %0b",
               got.symbol, got.has_symbol, got.sequence_end);
        errors++;
        return;
      end
      want = symbols_due.pop_front();
      if (got.symbol !== want.symbol) begin
        $error("symbol: expected %0d, got %0d", want.symbol, got.symbol);
        errors++;
      end
      if (got.has_symbol !== want.has_symbol) begin
        $error("has_symbol: expected %0b, got %0b", want.has_symbol, got.has_symbol);
        errors++;
      end
      if (got.sequence_end !== want.sequence_end) begin
        $error("sequence_end: expected %0b, got %0b", want.sequence_end, got.sequence_end);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  ctcgd_cfg_if    cfg_if ();
  ctcgd_score_if  in_if ();
  ctcgd_result_if out_if ();

  ctc_greedy_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  best_path_board tracker;

  int       burst_left   = 0;
  int       quiet_cycles = 0;
  int       rx_left      = 0;
  rx_mode_e rx_mode      = RX_OPEN;

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // monitor: every request is sampled at the rising edge, the scoreboard
  // follows config writes and scores in order and checks each result
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch
    bit       moved;
    decoded_t seen;
    moved = 1'b0;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        tracker.write_reg(cfg_if.index, cfg_if.data);
        moved = 1'b1;
      end
      if (in_if.valid && in_if.ready) begin
        tracker.note_score(in_if.score);
        moved = 1'b1;
      end
      if (out_if.valid && out_if.ready) begin
        seen.symbol       = out_if.symbol;
        seen.has_symbol   = out_if.has_symbol;
        seen.sequence_end = out_if.sequence_end;
        tracker.check_result(seen);
        moved = 1'b1;
      end
      // watchdog: a hung block stops the run here
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: ready follows a mode that changes after a random stretch, so
  // stalls land on every phase of the block, with open stretches in between
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 150);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:   out_if.ready <= 1'b1;
      RX_RANDOM: out_if.ready <= 1'($urandom_range(0, 1));
      RX_CHOKED: out_if.ready <= ($urandom_range(0, 7) == 0);
      default:   out_if.ready <= ((rx_left % 4) < 2);
    endcase
  end

  // one register write; valid stays up so that writes can follow back to back
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic close_cfg();
    cfg_if.valid <= 1'b0;
  endtask

  // one score request; the sender runs in bursts with random gaps between
  task automatic send_score(input logic [ScoreW-1:0] score);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      // now and then a long burst with no idling at all
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40);
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.score <= score;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // bring the block to idle: all results in, then time for scores that
  // close no result to leave the queue
  task automatic settle();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [ScoreW-1:0]   pattern[$];
    logic [ScoreW-1:0]   score;
    logic [CfgDataW-1:0] data;
    logic [31:0]         r;
    int                  sent;
    int                  len;
    int                  eff;
    int                  pick;

    tracker      = new();
    rst_ni       = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data  = '0;
    in_if.valid  = 1'b0;
    in_if.score  = '0;
    out_if.ready = 1'b0;

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // int8 extremes, ties going to the earliest class, a repeated winner
    // that is suppressed, a blank winner closing the sequence; the upper
    // bits of a quantized score are don't-care
    write_reg(REG_CLASS_COUNT, 32'd3);
    write_reg(REG_STEP_COUNT, 32'd3);
    write_reg(REG_QUANTIZED_MODE, 32'd1);
    write_reg(REG_ZERO_POINT, 32'h0000_0080);
    write_reg(REG_DEQUANT_SCALE, 32'h7fff_ffff);
    close_cfg();
    pattern = '{32'h0000_0080, 32'h0000_007f, 32'h0000_007f,
                32'hffff_ff00, 32'h0000_0001, 32'h0000_0001,
                32'h0000_007f, 32'h0000_0000, 32'h0000_0080};
    foreach (pattern[k]) send_score(pattern[k]);

    // zero counts saturate to one, direct mode with Q16.16 extremes,
    // writes to unused indexes change nothing
    settle();
    write_reg(REG_CLASS_COUNT, 32'd0);
    write_reg(REG_STEP_COUNT, 32'd0);
    write_reg(REG_QUANTIZED_MODE, 32'd0);
    write_reg(REG_ZERO_POINT, 32'h0000_007f);
    write_reg(REG_DEQUANT_SCALE, 32'h8000_0000);
    for (int i = REG_FIRST_UNUSED; i < 2 ** CfgIdxW; i++) write_reg(CfgIdxW'(i), $urandom);
    close_cfg();
    pattern = '{32'h8000_0000, 32'h7fff_ffff};
    foreach (pattern[k]) send_score(pattern[k]);

    // a blank timestep between two equal winners lets the second one through
    settle();
    write_reg(REG_CLASS_COUNT, 32'd2);
    write_reg(REG_STEP_COUNT, 32'd4);
    close_cfg();
    pattern = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'h0000_0001,
                32'h0000_0000, 32'h0000_0001, 32'h0000_0005, 32'h0000_0005};
    foreach (pattern[k]) send_score(pattern[k]);

    // counts shrunk below the current position end the timestep, and then
    // the sequence, on the next score
    send_score(32'h0000_0003);
    settle();
    write_reg(REG_CLASS_COUNT, 32'd1);
    close_cfg();
    send_score(32'h7fff_ffff);
    settle();
    write_reg(REG_STEP_COUNT, 32'd6);
    close_cfg();
    send_score(32'hffff_ffff);
    send_score(32'h0000_0000);
    settle();
    write_reg(REG_STEP_COUNT, 32'd1);
    close_cfg();
    send_score(32'h0000_0002);

    // random phases: new settings while idle, then a run of scores that
    // mostly fills whole timesteps but often stops in the middle of one
    sent = 0;
    while (sent < RandomItems) begin
      settle();
      if ($urandom_range(0, 3) != 0) begin
        data = $urandom;
        pick = $urandom_range(0, 39);
        if (pick == 0) data[ClassCntW-1:0] = '0;
        else if (pick == 1) data[ClassCntW-1:0] = ClassCntW'($urandom_range(256, 511));
        else data[ClassCntW-1:0] = ClassCntW'($urandom_range(1, 6));
        write_reg(REG_CLASS_COUNT, data);
      end
      if ($urandom_range(0, 3) != 0) begin
        data = $urandom;
        pick = $urandom_range(0, 19);
        if (pick == 0) data[StepCntW-1:0] = '0;
        else if (pick == 1) data[StepCntW-1:0] = StepCntW'($urandom_range(64, 127));
        else data[StepCntW-1:0] = StepCntW'($urandom_range(1, 5));
        write_reg(REG_STEP_COUNT, data);
      end
      if ($urandom_range(0, 3) != 0) write_reg(REG_QUANTIZED_MODE, $urandom);
      if ($urandom_range(0, 3) != 0) begin
        data = $urandom;
        pick = $urandom_range(0, 5);
        if (pick == 0) data[ZpW-1:0] = 8'h80;
        else if (pick == 1) data[ZpW-1:0] = 8'h7f;
        write_reg(REG_ZERO_POINT, data);
      end
      if ($urandom_range(0, 3) != 0) begin
        r = $urandom;
        case ($urandom_range(0, 7))
          0:       data = 32'h8000_0000;
          1:       data = 32'h7fff_ffff;
          2:       data = '0;
          3, 4:    data = {{14{r[17]}}, r[17:0]};
          default: data = r;
        endcase
        write_reg(REG_DEQUANT_SCALE, data);
      end
      if ($urandom_range(0, 7) == 0)
        write_reg(CfgIdxW'($urandom_range(REG_FIRST_UNUSED, 2 ** CfgIdxW - 1)), $urandom);
      close_cfg();

      // full-width timesteps are rare and kept to about one per phase
      eff = tracker.class_limit();
      if (eff > 8) len = eff + $urandom_range(0, 8);
      else len = eff * $urandom_range(2, 8) + $urandom_range(0, eff - 1);

      for (int k = 0; k < len; k++) begin
        score = $urandom;
        case ($urandom_range(0, 7))
          // fully random word
          0, 1: ;
          // tiny values, so that ties and blank winners come often
          2, 3: begin
            if (tracker.quant) score[7:0] = 8'($urandom_range(0, 3));
            else score = $urandom_range(0, 3);
          end
          // extremes of the int8 and of the Q16.16 range
          4: begin
            case ($urandom_range(0, 3))
              0:       score[7:0] = 8'h80;
              1:       score[7:0] = 8'h7f;
              2:       score = 32'h8000_0000;
              default: score = 32'h7fff_ffff;
            endcase
          end
          // moderate values around zero in direct mode
          default: begin
            if (!tracker.quant) score = {{16{score[15]}}, score[15:0]};
          end
        endcase
        send_score(score);
        sent++;
      end
    end

    // let everything drain, then give a late result time to show up
    in_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (tracker.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
